[hdl/tsr_pkg.sv]
// ============================================================================
// tsr_pkg - shared types and constants of the tapered segment renderer
// Actions, register indexes, store geometry and controller/datapath links.
// ============================================================================
package tsr_pkg;

   // frame store geometry
   localparam int PIXEL_COUNT = 64;
   localparam int ADDR_W      = $clog2(PIXEL_COUNT);
   localparam int VIS_W       = 7;
   localparam int COLOR_W     = 24;
   localparam int CHAN_W      = 8;
   localparam int CHANNELS    = 3;

   // action codes
   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_DRAW  = 2'd1;
   localparam logic [1:0] ACT_SHOW  = 2'd2;

   // register indexes
   localparam logic CSR_STRIP_LENGTH = 1'b0;
   localparam logic CSR_EDGE_MARGIN  = 1'b1;

   // register reset values
   localparam logic [VIS_W-1:0] STRIP_LENGTH_RST = 7'd60;
   localparam logic [7:0]       EDGE_MARGIN_RST  = 8'd4;

   // commands from controller to datapath
   typedef struct packed {
      logic load;        // latch a new action
      logic clear;       // drop every stored pixel
      logic div_step;    // one bit of the channel divisions
      logic issue;       // read store entry, register ramp values
      logic blend;       // blend neighboring ramp values
      logic write;       // saturating add and store write
      logic advance;     // move to the next segment step
      logic show_issue;  // read and emit one strip pixel
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic div_done;    // last division bit this cycle
      logic in_range;    // current step lands on the visible strip
      logic step_last;   // current step is the final one
      logic show_empty;  // no visible pixels
      logic show_last;   // current show pixel is the final one
      logic rsp_pending; // result on the output this cycle
   } stat_type;

endpackage

[hdl/tsr_ram.sv]
// ============================================================================
// tsr_ram - generic single write, single read RAM
// One write port and one read port with registered read data.
// ============================================================================
module tsr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/tsr_div.sv]
// ============================================================================
// tsr_div - three lane restoring divider
// Divides each color channel by the segment length plus one, one bit a cycle.
// ============================================================================
module tsr_div
   import tsr_pkg::*;
(
   input  logic                          clock,
   input  logic                          start,
   input  logic                          step,
   input  logic [COLOR_W-1:0]            dividend,
   input  logic [CHAN_W:0]               divisor,
   output logic [COLOR_W-1:0]            quotient,
   output logic                          done
);

   logic [CHAN_W-1:0] rem_ff [CHANNELS];
   logic [CHAN_W-1:0] rem_in [CHANNELS];
   logic [COLOR_W-1:0] dvd_ff, dvd_in;
   logic [COLOR_W-1:0] quo_ff, quo_in;
   logic [CHAN_W:0]    div_ff;
   logic [2:0]         cnt_ff;

   // one restoring step per lane
   always_comb begin
      logic [CHAN_W:0] trial;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         trial = {rem_ff[c], dvd_ff[c*CHAN_W + CHAN_W-1]};
         if (trial >= div_ff) begin
            rem_in[c] = CHAN_W'(trial - div_ff);
            quo_in[c*CHAN_W +: CHAN_W] = {quo_ff[c*CHAN_W +: CHAN_W-1], 1'b1};
         end else begin
            rem_in[c] = trial[CHAN_W-1:0];
            quo_in[c*CHAN_W +: CHAN_W] = {quo_ff[c*CHAN_W +: CHAN_W-1], 1'b0};
         end
         dvd_in[c*CHAN_W +: CHAN_W] = {dvd_ff[c*CHAN_W +: CHAN_W-1], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         for (int c = 0; c < CHANNELS; c++) begin
            rem_ff[c] <= '0;
         end
         dvd_ff <= dividend;
         quo_ff <= '0;
         div_ff <= divisor;
         cnt_ff <= '0;
      end else if (step) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + 3'd1;
      end
   end

   assign quotient = quo_ff;
   assign done     = step && (cnt_ff == 3'd7);

endmodule

[hdl/tsr_datapath.sv]
// ============================================================================
// tsr_datapath - frame store, ramp and blend arithmetic, show output
// Holds the configuration, the store with its valid bits and step counters.
// ============================================================================
module tsr_datapath
   import tsr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [15:0]         req_position,
   input  logic [7:0]          req_segment_length,
   input  logic [COLOR_W-1:0]  req_color,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [7:0]          csr_data,
   output logic                rsp_strobe,
   output logic [ADDR_W-1:0]   rsp_pixel_index,
   output logic [COLOR_W-1:0]  rsp_pixel_color,
   output logic                rsp_last
);

   // configuration
   logic [VIS_W-1:0] strip_length_ff;
   logic [7:0]       edge_margin_ff;

   // latched draw parameters and counters
   logic [7:0]        base_ff, frac_ff, n_ff, i_ff;
   logic [ADDR_W-1:0] k_ff;

   // per-pixel pipeline
   logic [CHAN_W-1:0] ramp_a_ff [CHANNELS];
   logic [CHAN_W-1:0] ramp_b_ff [CHANNELS];
   logic [CHAN_W-1:0] ramp_a_in [CHANNELS];
   logic [CHAN_W-1:0] ramp_b_in [CHANNELS];
   logic [CHAN_W-1:0] blend_ff  [CHANNELS];
   logic [CHAN_W-1:0] blend_in  [CHANNELS];
   logic [ADDR_W-1:0] idx_ff;
   logic              idx_valid_ff;

   // store valid bits and output registers
   logic [PIXEL_COUNT-1:0] valid_ff;
   logic                   rsp_pending_ff;
   logic [ADDR_W-1:0]      rsp_index_ff;
   logic                   rsp_last_ff;
   logic                   rsp_valid_bit_ff;

   logic [COLOR_W-1:0] quotient;
   logic               div_done;
   logic [VIS_W-1:0]   vis;
   logic [7:0]         d, k1;
   logic [ADDR_W-1:0]  idx;
   logic               in_range;
   logic               ramp_b_zero;
   logic [COLOR_W-1:0] ram_rd_data, ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;

   tsr_div u_div (
      .clock    (clock),
      .start    (cmd.load),
      .step     (cmd.div_step),
      .dividend (req_color),
      .divisor  ({1'b0, req_segment_length} + 9'd1),
      .quotient (quotient),
      .done     (div_done)
   );

   tsr_ram #(.WIDTH(COLOR_W), .DEPTH(PIXEL_COUNT)) u_store (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (idx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // visible window and step position
   always_comb begin
      vis = (strip_length_ff > VIS_W'(PIXEL_COUNT)) ? VIS_W'(PIXEL_COUNT) : strip_length_ff;
      d   = base_ff + i_ff;
      k1  = i_ff + 8'd1;
      idx = ADDR_W'(d - edge_margin_ff);
      in_range = (d >= edge_margin_ff) &&
                 ({1'b0, d} < ({2'b00, vis} + {1'b0, edge_margin_ff}));
      ramp_b_zero = (k1 == 8'd0) || ({1'b0, k1} == ({1'b0, n_ff} + 9'd1));
   end

   // ramp values at this step and the next
   always_comb begin
      logic [15:0] prod_a, prod_b;
      for (int c = 0; c < CHANNELS; c++) begin
         prod_a = quotient[c*CHAN_W +: CHAN_W] * i_ff;
         prod_b = quotient[c*CHAN_W +: CHAN_W] * k1;
         ramp_a_in[c] = (i_ff == 8'd0) ? '0 : prod_a[7:0];
         ramp_b_in[c] = ramp_b_zero ? '0 : prod_b[7:0];
      end
   end

   // fractional blend of neighboring ramp values
   always_comb begin
      logic [16:0] part_a, part_b, sum;
      for (int c = 0; c < CHANNELS; c++) begin
         part_a = ramp_a_ff[c] * ({1'b0, frac_ff} + 9'd1);
         part_b = 17'(ramp_b_ff[c] * (8'hff - frac_ff));
         sum    = part_a + part_b;
         blend_in[c] = sum[15:8];
      end
   end

   // saturating add onto the stored pixel
   always_comb begin
      logic [CHAN_W:0]   s;
      logic [CHAN_W-1:0] old;
      for (int c = 0; c < CHANNELS; c++) begin
         old = idx_valid_ff ? ram_rd_data[c*CHAN_W +: CHAN_W] : '0;
         s   = {1'b0, old} + {1'b0, blend_ff[c]};
         ram_wr_data[c*CHAN_W +: CHAN_W] = s[CHAN_W] ? 8'hff : s[CHAN_W-1:0];
      end
   end

   assign ram_rd_en   = cmd.issue || cmd.show_issue;
   assign ram_rd_addr = cmd.show_issue ? k_ff : idx;

   // configuration, valid bits and output flag
   always_ff @(posedge clock) begin
      if (reset) begin
         strip_length_ff <= STRIP_LENGTH_RST;
         edge_margin_ff  <= EDGE_MARGIN_RST;
         valid_ff        <= '0;
         rsp_pending_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_STRIP_LENGTH: strip_length_ff <= csr_data[VIS_W-1:0];
               CSR_EDGE_MARGIN:  edge_margin_ff  <= csr_data;
               default: ;
            endcase
         end
         if (cmd.clear) begin
            valid_ff <= '0;
         end else if (cmd.write) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         rsp_pending_ff <= cmd.show_issue;
      end
   end

   // draw parameters, counters and pixel pipeline
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff <= req_position[15:8];
         frac_ff <= req_position[7:0];
         n_ff    <= req_segment_length;
         i_ff    <= '0;
         k_ff    <= '0;
      end else begin
         if (cmd.advance) begin
            i_ff <= i_ff + 8'd1;
         end
         if (cmd.show_issue) begin
            k_ff <= k_ff + 1'b1;
         end
      end
      if (cmd.issue) begin
         ramp_a_ff    <= ramp_a_in;
         ramp_b_ff    <= ramp_b_in;
         idx_ff       <= idx;
         idx_valid_ff <= valid_ff[idx];
      end
      if (cmd.blend) begin
         blend_ff <= blend_in;
      end
      if (cmd.show_issue) begin
         rsp_index_ff     <= k_ff;
         rsp_last_ff      <= stat.show_last;
         rsp_valid_bit_ff <= valid_ff[k_ff];
      end
   end

   // status back to the controller
   always_comb begin
      stat.div_done    = div_done;
      stat.in_range    = in_range;
      stat.step_last   = (i_ff == n_ff);
      stat.show_empty  = (vis == '0);
      stat.show_last   = (({1'b0, k_ff} + VIS_W'(1)) == vis);
      stat.rsp_pending = rsp_pending_ff;
   end

   assign rsp_strobe      = rsp_pending_ff;
   assign rsp_pixel_index = rsp_index_ff;
   assign rsp_pixel_color = rsp_valid_bit_ff ? ram_rd_data : '0;
   assign rsp_last        = rsp_last_ff;

endmodule

[hdl/tsr_ctrl.sv]
// ============================================================================
// tsr_ctrl - action sequencer of the tapered segment renderer
// Steps through division, per-pixel read-modify-write and show readout.
// ============================================================================
module tsr_ctrl
   import tsr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_action,
   input  stat_type   stat,
   output cmd_type    cmd,
   output logic       busy
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_STEP,
      S_BLEND,
      S_WRITE,
      S_SHOW
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign busy   = (state_ff != S_IDLE) || stat.rsp_pending;
   assign accept = start && !busy;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_CLEAR: cmd.clear = 1'b1;
                  ACT_DRAW: begin
                     cmd.load = 1'b1;
                     state_in = S_DIV;
                  end
                  ACT_SHOW: begin
                     cmd.load = 1'b1;
                     if (!stat.show_empty) begin
                        state_in = S_SHOW;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (stat.in_range) begin
               cmd.issue = 1'b1;
               state_in  = S_BLEND;
            end else if (stat.step_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_BLEND: begin
            cmd.blend = 1'b1;
            state_in  = S_WRITE;
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            if (stat.step_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_STEP;
            end
         end
         S_SHOW: begin
            cmd.show_issue = 1'b1;
            if (stat.show_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/tapered_segment_renderer.sv]
// ============================================================================
// tapered_segment_renderer - tapered segment renderer for an LED strip
// Adds anti-aliased tapered segments into a 64 pixel store and reads it out.
// ============================================================================
// Usage:
//   An action transfers at a clock edge with start high and busy low; req_*
//   carry the action, the 8.8 position, the segment length and the color.
//   Draw first runs the three channel divisions bit by bit, then walks the
//   n+1 segment steps: a step off the visible strip just advances, a drawn
//   step goes through store read, blend and saturating write.
//   Show emits every visible pixel, one per cycle on rsp_* with rsp_strobe
//   high, the first one once its store read is registered, rsp_last on the
//   final one; busy stays high until the last pixel has left. The receiver
//   cannot stall.
//   csr_* writes strip_length (index 0) and edge_margin (index 1); the user
//   writes them only while idle, the block itself does not enforce this.
//   Reset empties the store at once through per-entry valid bits and loads
//   strip_length 60 and edge_margin 4; no clearing pass is needed.
// ============================================================================
module tapered_segment_renderer
   import tsr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic [15:0]        req_position,
   input  logic [7:0]         req_segment_length,
   input  logic [COLOR_W-1:0] req_color,
   output logic               rsp_strobe,
   output logic [ADDR_W-1:0]  rsp_pixel_index,
   output logic [COLOR_W-1:0] rsp_pixel_color,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [7:0]         csr_data
);

   cmd_type  cmd;
   stat_type stat;

   tsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   tsr_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_position       (req_position),
      .req_segment_length (req_segment_length),
      .req_color          (req_color),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_pixel_index    (rsp_pixel_index),
      .rsp_pixel_color    (rsp_pixel_color),
      .rsp_last           (rsp_last)
   );

endmodule

[hdl/tsr_checker.sv]
// ============================================================================
// tsr_checker - port level checks of the tapered segment renderer
// Watches show readout ordering and busy against result transfers.
// ============================================================================
module tsr_checker
   import tsr_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [1:0]         req_action,
   input logic [15:0]        req_position,
   input logic [7:0]         req_segment_length,
   input logic [COLOR_W-1:0] req_color,
   input logic               rsp_strobe,
   input logic [ADDR_W-1:0]  rsp_pixel_index,
   input logic [COLOR_W-1:0] rsp_pixel_color,
   input logic               rsp_last,
   input logic               csr_wr_en,
   input logic               csr_index,
   input logic [7:0]         csr_data
);

   // a result only appears while the block is busy
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result transfer while not busy");

   // show pixels follow each other in index order without gaps
   a_show_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=>
         rsp_strobe && (rsp_pixel_index == $past(rsp_pixel_index) + 1'b1))
      else $error("show run broken or out of order");

   // nothing follows the last pixel directly
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("result after last pixel");

   // the first pixel follows a show transfer and its registered store read
   a_first_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_pixel_index == '0) |->
         $past(start && !busy && (req_action == ACT_SHOW), 2))
      else $error("first pixel without show transfer");

endmodule

bind tapered_segment_renderer tsr_checker u_checker (.*);
